FILE: rtl/core/bsr_pkg.sv
// Package for the byte stack with rotate: sizes, command and status codes,
// and the command struct that the controller hands to the row of cells.
// No dependencies.
`default_nettype none

package bsr_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 8;
    localparam int OP_W    = 3;
    localparam int CFG_W   = 6;
    localparam int ROT_W   = 6;
    localparam int ST_W    = 2;
    localparam int FILL_W  = 6;
    localparam int CMP_W   = (CNT_W > ROT_W) ? CNT_W : ROT_W;
    localparam int CAP_RST = (32 > DEPTH) ? DEPTH : 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_ROT_UP = 3'd3,
        OP_ROT_DN = 3'd4,
        OP_DUP    = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FEW   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        INJ_PUSH = 2'd0,
        INJ_TOP  = 2'd1,
        INJ_DEEP = 2'd2
    } t_inj;

    typedef struct packed {
        logic             shift_dn;
        logic             shift_up;
        logic             rot_up;
        logic             rot_dn;
        logic [CMP_W-1:0] n;
        t_inj             inj;
    } t_row_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/bsr_cell.sv
// One stack cell: holds one byte and takes it from a neighbor, from the top
// cell or keeps it, as the row command says. Depends on bsr_pkg.
`default_nettype none

module bsr_cell (
    input  wire                          i_clk,
    input  wire bsr_pkg::t_row_cmd       i_cmd,
    input  wire [bsr_pkg::CMP_W-1:0]     i_idx,
    input  wire [bsr_pkg::DATA_W-1:0]    i_prev,
    input  wire [bsr_pkg::DATA_W-1:0]    i_next,
    input  wire [bsr_pkg::DATA_W-1:0]    i_top,
    output logic [bsr_pkg::DATA_W-1:0]   o_data
);
    import bsr_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_in_range;
    logic              w_is_last;

    assign w_in_range = i_idx < i_cmd.n;
    assign w_is_last  = (i_idx + CMP_W'(1)) == i_cmd.n;

    always_comb begin
        n_data = r_data;
        if (i_cmd.shift_dn || (i_cmd.rot_dn && w_in_range)) begin
            n_data = i_prev;
        end else if (i_cmd.shift_up || (i_cmd.rot_up && w_in_range && !w_is_last)) begin
            n_data = i_next;
        end else if (i_cmd.rot_up && w_is_last) begin
            n_data = i_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: rtl/core/bsr_ctrl.sv
// Controller: capacity register, fill count, command decode, status and the
// result register with its handshake. Depends on bsr_pkg.
`default_nettype none

module bsr_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [bsr_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [bsr_pkg::OP_W-1:0]      i_opcode,
    input  wire [bsr_pkg::ROT_W-1:0]     i_rotate_count,
    input  wire [bsr_pkg::DATA_W-1:0]    i_top,
    output bsr_pkg::t_row_cmd            o_cmd,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bsr_pkg::DATA_W-1:0]   o_read_value,
    output logic [bsr_pkg::ST_W-1:0]     o_status,
    output logic [bsr_pkg::FILL_W-1:0]   o_fill_level
);
    import bsr_pkg::*;

    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  n_cap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_value;
    logic [DATA_W-1:0] n_read_value;
    t_status           r_status;
    t_status           n_status;
    t_row_cmd          n_cmd;
    logic              w_fire;
    logic              w_empty;
    logic              w_full;
    logic [CMP_W-1:0]  w_n;
    logic [CMP_W-1:0]  w_count;
    logic [CMP_W-1:0]  w_cfg;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_empty    = r_count == '0;
    assign w_full     = r_count >= r_cap;
    assign w_n        = CMP_W'(i_rotate_count);
    assign w_count    = CMP_W'(r_count);
    assign w_cfg      = CMP_W'(i_cfg_data);

    always_comb begin
        if (w_cfg == '0) begin
            n_cap = CNT_W'(1);
        end else if (w_cfg > CMP_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(w_cfg);
        end
    end

    always_comb begin
        n_cmd        = '0;
        n_cmd.n      = w_n;
        n_cmd.inj    = INJ_PUSH;
        n_status     = ST_OK;
        n_read_value = '0;
        n_count      = r_count;
        unique case (i_opcode) inside
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cmd.shift_dn = 1'b1;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read_value = i_top;
                    if (i_opcode == OP_POP) begin
                        n_cmd.shift_up = 1'b1;
                        n_count        = r_count - CNT_W'(1);
                    end
                end
            end
            OP_ROT_UP, OP_ROT_DN: begin
                if (w_n == '0 || w_n > w_count) begin
                    n_status = ST_FEW;
                end else if (i_opcode == OP_ROT_UP) begin
                    n_cmd.rot_up = 1'b1;
                end else begin
                    n_cmd.rot_dn = 1'b1;
                    n_cmd.inj    = INJ_DEEP;
                end
            end
            OP_DUP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cmd.shift_dn = 1'b1;
                    n_cmd.inj      = INJ_TOP;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd = n_cmd;
        if (!w_fire) begin
            o_cmd.shift_dn = 1'b0;
            o_cmd.shift_up = 1'b0;
            o_cmd.rot_up   = 1'b0;
            o_cmd.rot_dn   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CNT_W'(CAP_RST);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_fill_level = FILL_W'(CMP_W'(r_count));

endmodule

`default_nettype wire

FILE: rtl/core/byte_stack_with_rotate_core.sv
// Top level of the byte stack with rotate: the controller and a row of cells
// with the top entry in cell 0. Depends on bsr_pkg, bsr_cell and bsr_ctrl.
//
//   channel  direction  handshake                   word
//   in       input      i_in_valid / o_in_ready     opcode, push value, rotate count
//   out      output     o_out_valid / i_out_ready   read value, status, fill level
//   cfg      input      i_cfg_we                    capacity
//
// All cells shift in parallel in the cycle a command is accepted, and its word
// sits in the result register from the next cycle.
// A new command is taken while the result register is empty or being read.
// Reset clears the fill count and the result valid and sets capacity to 32.
// Stalls on the output side hold the result and hold off the input side.
`default_nettype none

module byte_stack_with_rotate_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [bsr_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [bsr_pkg::OP_W-1:0]      i_opcode,
    input  wire [bsr_pkg::DATA_W-1:0]    i_push_value,
    input  wire [bsr_pkg::ROT_W-1:0]     i_rotate_count,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bsr_pkg::DATA_W-1:0]   o_read_value,
    output logic [bsr_pkg::ST_W-1:0]     o_status,
    output logic [bsr_pkg::FILL_W-1:0]   o_fill_level
);
    import bsr_pkg::*;

    t_row_cmd          w_cmd;
    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DATA_W-1:0] w_inject;
    logic [DATA_W-1:0] w_deep;

    bsr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_rotate_count (i_rotate_count),
        .i_top          (w_data[0]),
        .o_cmd          (w_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_value   (o_read_value),
        .o_status       (o_status),
        .o_fill_level   (o_fill_level)
    );

    assign w_deep = w_data[IDX_W'(w_cmd.n - CMP_W'(1))];

    always_comb begin
        case (w_cmd.inj)
            INJ_TOP:  w_inject = w_data[0];
            INJ_DEEP: w_inject = w_deep;
            default:  w_inject = i_push_value;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;

        if (i == 0) begin : g_first
            assign w_prev = w_inject;
        end else begin : g_mid
            assign w_prev = w_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_data[i+1];
        end

        bsr_cell u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_idx  (CMP_W'(i)),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_top  (w_data[0]),
            .o_data (w_data[i])
        );
    end

endmodule

`default_nettype wire

FILE: tb/bsr_result_check.sv
// Result checker for the byte stack with rotate: keeps its own copy of the stack,
// predicts one result word per accepted command and compares it with the output.
// Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_result_check (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [bsr_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire [bsr_pkg::OP_W-1:0]      i_opcode,
    input  wire [bsr_pkg::DATA_W-1:0]    i_push_value,
    input  wire [bsr_pkg::ROT_W-1:0]     i_rotate_count,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire [bsr_pkg::DATA_W-1:0]    i_read_value,
    input  wire [bsr_pkg::ST_W-1:0]      i_status,
    input  wire [bsr_pkg::FILL_W-1:0]    i_fill_level,
    output int                           o_pending_words,
    output int                           o_fail_count
);

    import bsr_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        t_status           status;
        logic [FILL_W-1:0] fill_level;
    } stack_word_t;

    logic [DATA_W-1:0] stack_bytes [DEPTH];
    int unsigned       held;
    logic [CFG_W-1:0]  capacity_reg;
    stack_word_t       expected_words [$];
    int                fails;

    function automatic int unsigned usable_capacity();
        if (capacity_reg == 0) return 1;
        if (capacity_reg > DEPTH) return DEPTH;
        return capacity_reg;
    endfunction

    function automatic t_status push_byte(input logic [DATA_W-1:0] value);
        if (held >= usable_capacity()) return ST_FULL;
        stack_bytes[held] = value;
        held++;
        return ST_OK;
    endfunction

    function automatic t_status rotate_top(input int unsigned n, input bit up);
        int unsigned base;
        int unsigned i;
        logic [DATA_W-1:0] moved;
        if (n == 0 || n > held) return ST_FEW;
        base = held - n;
        if (up) begin
            moved = stack_bytes[held - 1];
            for (i = held - 1; i > base; i--) stack_bytes[i] = stack_bytes[i - 1];
            stack_bytes[base] = moved;
        end else begin
            moved = stack_bytes[base];
            for (i = base; i + 1 < held; i++) stack_bytes[i] = stack_bytes[i + 1];
            stack_bytes[held - 1] = moved;
        end
        return ST_OK;
    endfunction

    function automatic stack_word_t predict_word(input logic [OP_W-1:0] op,
                                                 input logic [DATA_W-1:0] value,
                                                 input logic [ROT_W-1:0] n);
        stack_word_t w;
        w.read_value = '0;
        w.status = ST_OK;
        case (op)
            OP_PUSH: begin
                w.status = push_byte(value);
            end
            OP_POP, OP_PEEK: begin
                if (held == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    w.read_value = stack_bytes[held - 1];
                    if (op == OP_POP) held--;
                end
            end
            OP_ROT_UP: begin
                w.status = rotate_top(n, 1'b1);
            end
            OP_ROT_DN: begin
                w.status = rotate_top(n, 1'b0);
            end
            OP_DUP: begin
                if (held == 0) w.status = ST_EMPTY;
                else w.status = push_byte(stack_bytes[held - 1]);
            end
            default: begin
            end
        endcase
        w.fill_level = FILL_W'(held);
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        stack_word_t got;
        stack_word_t want;
        if (!i_rst_n) begin
            held = 0;
            capacity_reg = CFG_W'(CAP_RST);
            expected_words.delete();
        end else begin
            if (i_cfg_we) capacity_reg = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got.read_value = i_read_value;
                got.status = t_status'(i_status);
                got.fill_level = i_fill_level;
                if (expected_words.size() == 0) begin
                    $error("result word arrived with no command waiting");
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.read_value !== want.read_value) begin
                        $error("read_value expected %0d, got %0d",
                               want.read_value, got.read_value);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.fill_level !== want.fill_level) begin
                        $error("fill_level expected %0d, got %0d",
                               want.fill_level, got.fill_level);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(predict_word(i_opcode, i_push_value,
                                                      i_rotate_count));
            end
        end
        o_pending_words <= expected_words.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/byte_stack_with_rotate_core_tb.sv
// Testbench top for the byte stack with rotate: drives directed and random command
// words under random stalls and eight capacity settings and gives the verdict.
// Depends on bsr_pkg, byte_stack_with_rotate_core and bsr_result_check.
`timescale 1ns / 1ps

module byte_stack_with_rotate_core_tb;

    import bsr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 100;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic [OP_W-1:0]     opcode = '0;
    logic [DATA_W-1:0]   push_value = '0;
    logic [ROT_W-1:0]    rotate_count = '0;
    logic                rx_ready = 1'b0;
    logic                rx_hold = 1'b0;
    logic                hold_request = 1'b0;
    bit                  tx_idles = 1'b1;
    bit                  rx_idles = 1'b1;
    wire                 out_ready = rx_ready && !rx_hold;
    logic                in_ready;
    logic                out_valid;
    logic [DATA_W-1:0]   read_value;
    logic [ST_W-1:0]     status;
    logic [FILL_W-1:0]   fill_level;
    int                  pending_words;
    int                  fail_count;

    byte_stack_with_rotate_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_opcode       (opcode),
        .i_push_value   (push_value),
        .i_rotate_count (rotate_count),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_read_value   (read_value),
        .o_status       (status),
        .o_fill_level   (fill_level)
    );

    bsr_result_check u_result_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_push_value    (push_value),
        .i_rotate_count  (rotate_count),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_read_value    (read_value),
        .i_status        (status),
        .i_fill_level    (fill_level),
        .o_pending_words (pending_words),
        .o_fail_count    (fail_count)
    );

    initial begin : clock_gen
        forever #10 clk = ~clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : result_drain
        int gap;
        @(posedge rst_n);
        forever begin
            gap = rx_idles ? $urandom_range(0, 18) : 0;
            @(negedge clk);
            if (gap > 0) begin
                rx_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rx_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    initial begin : long_hold
        wait (hold_request);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                             input logic [ROT_W-1:0] n);
        int gap;
        gap = tx_idles ? $urandom_range(0, 18) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        push_value <= value;
        rotate_count <= n;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words != 0) @(posedge clk);
    endtask

    task automatic program_capacity(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int words, input bit with_hold);
        int push_pct;
        int pick;
        int kind;
        logic [OP_W-1:0] op;
        logic [ROT_W-1:0] n;
        push_pct = 50;
        for (int i = 0; i < words; i++) begin
            if (i % 25 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 45;
                    default: push_pct = 15;
                endcase
                tx_idles = ($urandom_range(0, 3) != 0);
                rx_idles = ($urandom_range(0, 3) != 0);
            end
            if (with_hold && i == 30) hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            kind = $urandom_range(0, 99);
            if (pick < push_pct) op = OP_PUSH;
            else if (kind < 40) op = OP_POP;
            else if (kind < 52) op = OP_PEEK;
            else if (kind < 70) op = OP_ROT_UP;
            else if (kind < 88) op = OP_ROT_DN;
            else if (kind < 97) op = OP_DUP;
            else op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            kind = $urandom_range(0, 9);
            if (kind < 5) n = ROT_W'($urandom_range(1, 6));
            else if (kind < 8) n = ROT_W'($urandom_range(0, 32));
            else n = ROT_W'($urandom_range(0, 63));
            send_word(op, DATA_W'($urandom_range(0, 255)), n);
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] capacities [8];
        capacities = '{6'd32, 6'd4, 6'd1, 6'd0, 6'd63, 6'd2, 6'd45, 6'd17};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Commands on an empty stack, then a short stack of extreme bytes.
        send_word(OP_POP, 8'h00, 6'd0);
        send_word(OP_PEEK, 8'hFF, 6'd63);
        send_word(OP_DUP, 8'h00, 6'd0);
        send_word(OP_ROT_UP, 8'h00, 6'd1);
        send_word(OP_ROT_DN, 8'h00, 6'd0);
        send_word(OP_SPARE_6, 8'hFF, 6'd63);
        send_word(OP_SPARE_7, 8'h00, 6'd0);
        send_word(OP_PUSH, 8'h00, 6'd63);
        send_word(OP_PUSH, 8'hFF, 6'd0);
        send_word(OP_PUSH, 8'hA5, 6'd0);
        send_word(OP_PUSH, 8'h5A, 6'd0);
        send_word(OP_PEEK, 8'h00, 6'd0);
        send_word(OP_DUP, 8'h00, 6'd0);
        send_word(OP_ROT_UP, 8'h00, 6'd5);
        send_word(OP_ROT_DN, 8'h00, 6'd5);
        send_word(OP_ROT_UP, 8'h00, 6'd2);
        send_word(OP_ROT_DN, 8'h00, 6'd3);
        send_word(OP_ROT_UP, 8'h00, 6'd1);
        send_word(OP_ROT_DN, 8'h00, 6'd6);
        send_word(OP_ROT_UP, 8'h00, 6'd0);
        send_word(OP_ROT_UP, 8'h00, 6'd63);
        send_word(OP_POP, 8'h00, 6'd0);
        send_word(OP_POP, 8'h00, 6'd0);
        drain_results();

        for (int p = 0; p < 8; p++) begin
            program_capacity(capacities[p]);
            random_phase(PHASE_WORDS, p == 0);
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
